>>> hw/rtl/vct_pkg.sv
package vct_pkg;

    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 16;
    localparam int ZOOM_W     = 16;
    localparam int CENTER_W   = 31;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int NUM_STAGES = 6;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef enum logic
    {
        OP_W2S = 1'b0,
        OP_S2W = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        REG_VIEW_X     = 3'd0,
        REG_VIEW_Y     = 3'd1,
        REG_ZOOM       = 3'd2,
        REG_ZOOM_RECIP = 3'd3,
        REG_ROT_COS    = 3'd4,
        REG_ROT_SIN    = 3'd5,
        REG_CENTER_X   = 3'd6,
        REG_CENTER_Y   = 3'd7
    } reg_idx_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0] view_x;
        logic signed [COORD_W-1:0] view_y;
        logic        [ZOOM_W-1:0]  zoom_factor;
        logic        [ZOOM_W-1:0]  zoom_reciprocal;
        logic signed [TRIG_W-1:0]  rot_cos;
        logic signed [TRIG_W-1:0]  rot_sin;
        logic        [CENTER_W-1:0] center_x;
        logic        [CENTER_W-1:0] center_y;
    } cfg_t;

    localparam logic [ZOOM_W-1:0]        ZOOM_RESET = 16'd256;
    localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;

endpackage

>>> hw/rtl/vct_if.sv
interface vct_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (output valid, output operation, output point_x, output point_y,
                    input ready);
    modport sink (input valid, input operation, input point_x, input point_y,
                  output ready);
endinterface

interface vct_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               saturated;

    modport source (output valid, output result_x, output result_y, output saturated,
                    input ready);
    modport sink (input valid, input result_x, input result_y, input saturated,
                  output ready);
endinterface

>>> hw/rtl/view_coordinate_transform_unit.sv
// View coordinate transform: maps a point from world to screen space or back.
// Points arrive on pt_in (operation, point_x, point_y, Q20.12) and leave on
// pt_out (result_x, result_y, saturated). Each channel moves one transfer when
// valid and ready are both high.
// The datapath is a six-stage pipeline: offset subtract, first multiply,
// round, second multiply, round, final offset add with saturation. The block
// sustains one point per cycle while the receiver keeps ready high.
// When the receiver holds ready low while a result is waiting, all stages
// freeze together and pt_in.ready drops; nothing is lost or repeated, and
// empty stages do not absorb new points until the output is taken.
// The view, zoom, rotation and center registers sit on the APB port at byte
// address 4*index. Write them only while the pipeline is empty.
// Reset empties the pipeline and sets the identity view: zoom 1.0, cos 1.0,
// sin 0, zero view position and center.
module view_coordinate_transform_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vct_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vct_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vct_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    vct_in_if.sink                            pt_in,
    vct_out_if.source                         pt_out
);
    import vct_pkg::*;

    cfg_t                  cfg;
    logic                  cfg_wr;
    logic                  advance;
    logic [NUM_STAGES-1:0] stage_valid;

    assign pready = 1'b1;

    vct_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg_wr  (cfg_wr),
        .cfg     (cfg)
    );

    assign advance     = !stage_valid[NUM_STAGES-1] || pt_out.ready;
    assign pt_in.ready = advance;

    vct_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (pt_in.valid),
        .in_op       (pt_in.operation),
        .in_x        (pt_in.point_x),
        .in_y        (pt_in.point_y),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .out_x       (pt_out.result_x),
        .out_y       (pt_out.result_y),
        .out_sat     (pt_out.saturated)
    );

    assign pt_out.valid = stage_valid[NUM_STAGES-1];

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && pt_out.saturated |->
            (pt_out.result_x == COORD_MAX) || (pt_out.result_x == COORD_MIN) ||
            (pt_out.result_y == COORD_MAX) || (pt_out.result_y == COORD_MIN))
        else $error("saturated flag set without a clipped coordinate");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stage_valid))
        else $error("pipeline moved while the output was stalled");

    a_cfg_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(cfg))
        else $error("configuration changed without a register write");

endmodule

>>> hw/rtl/vct_cfg_regs.sv
module vct_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vct_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vct_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vct_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              cfg_wr,
    output vct_pkg::cfg_t                     cfg
);
    import vct_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (idx)
                REG_VIEW_X:     cfg_next.view_x          = pwdata;
                REG_VIEW_Y:     cfg_next.view_y          = pwdata;
                REG_ZOOM:       cfg_next.zoom_factor     = pwdata[ZOOM_W-1:0];
                REG_ZOOM_RECIP: cfg_next.zoom_reciprocal = pwdata[ZOOM_W-1:0];
                REG_ROT_COS:    cfg_next.rot_cos         = pwdata[TRIG_W-1:0];
                REG_ROT_SIN:    cfg_next.rot_sin         = pwdata[TRIG_W-1:0];
                REG_CENTER_X:   cfg_next.center_x        = pwdata[CENTER_W-1:0];
                REG_CENTER_Y:   cfg_next.center_y        = pwdata[CENTER_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_x          <= '0;
            cfg_reg.view_y          <= '0;
            cfg_reg.zoom_factor     <= ZOOM_RESET;
            cfg_reg.zoom_reciprocal <= ZOOM_RESET;
            cfg_reg.rot_cos         <= COS_RESET;
            cfg_reg.rot_sin         <= '0;
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_VIEW_X:     prdata = cfg_reg.view_x;
            REG_VIEW_Y:     prdata = cfg_reg.view_y;
            REG_ZOOM:       prdata = {16'd0, cfg_reg.zoom_factor};
            REG_ZOOM_RECIP: prdata = {16'd0, cfg_reg.zoom_reciprocal};
            REG_ROT_COS:    prdata = {{16{cfg_reg.rot_cos[TRIG_W-1]}}, cfg_reg.rot_cos};
            REG_ROT_SIN:    prdata = {{16{cfg_reg.rot_sin[TRIG_W-1]}}, cfg_reg.rot_sin};
            REG_CENTER_X:   prdata = {1'b0, cfg_reg.center_x};
            REG_CENTER_Y:   prdata = {1'b0, cfg_reg.center_y};
            default:        prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/vct_datapath.sv
module vct_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic                                 in_op,
    input  logic signed [vct_pkg::COORD_W-1:0]   in_x,
    input  logic signed [vct_pkg::COORD_W-1:0]   in_y,
    input  vct_pkg::cfg_t                        cfg,
    output logic [vct_pkg::NUM_STAGES-1:0]       stage_valid,
    output logic signed [vct_pkg::COORD_W-1:0]   out_x,
    output logic signed [vct_pkg::COORD_W-1:0]   out_y,
    output logic                                 out_sat
);
    import vct_pkg::*;

    // Offset differences, coefficients, first products and their rounded sums,
    // second products, rounded results and the result plus final offset.
    localparam int A_W  = COORD_W + 1;
    localparam int K_W  = TRIG_W + 1;
    localparam int M1_W = A_W + K_W;
    localparam int S1_W = M1_W + 2;
    localparam int P_W  = M1_W - 8;
    localparam int M2_W = P_W + K_W;
    localparam int S2_W = M2_W + 1;
    localparam int R_W  = 46;
    localparam int F_W  = R_W + 1;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-2:0] op_reg, op_next;

    logic signed [A_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic signed [M1_W-1:0] m0_reg, m0_next, m1_reg, m1_next;
    logic signed [M1_W-1:0] m2_reg, m2_next, m3_reg, m3_next;
    logic signed [P_W-1:0]  p_reg, p_next, q_reg, q_next;
    logic signed [M2_W-1:0] n0_reg, n0_next, n1_reg, n1_next;
    logic signed [M2_W-1:0] n2_reg, n2_next, n3_reg, n3_next;
    logic signed [R_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic                   sat_reg, sat_next;

    logic signed [A_W-1:0] view_x_a, view_y_a, center_x_a, center_y_a;
    logic signed [K_W-1:0] cos_k, sin_k, zoom_k, recip_k;
    logic signed [S1_W-1:0] s0, s1;
    logic signed [S2_W-1:0] t0, t1;
    logic signed [F_W-1:0]  fx, fy;
    logic                   sat_x, sat_y;

    // Round half up: add half an LSB, then arithmetic shift right.
    function automatic logic signed [P_W-1:0] round_first(
        input logic signed [S1_W-1:0] v,
        input logic                   w2s
    );
        logic signed [S1_W-1:0] r14;
        logic signed [S1_W-1:0] r8;
        r14 = (v + S1_W'(8192)) >>> 14;
        r8  = (v + S1_W'(128)) >>> 8;
        return w2s ? P_W'(r14) : P_W'(r8);
    endfunction

    function automatic logic signed [R_W-1:0] round_second(
        input logic signed [S2_W-1:0] v,
        input logic                   w2s
    );
        logic signed [S2_W-1:0] r14;
        logic signed [S2_W-1:0] r8;
        r14 = (v + S2_W'(8192)) >>> 14;
        r8  = (v + S2_W'(128)) >>> 8;
        return w2s ? R_W'(r8) : R_W'(r14);
    endfunction

    function automatic logic signed [COORD_W-1:0] clip(
        input  logic signed [F_W-1:0] v,
        output logic                  hit
    );
        hit = 1'b0;
        if (v > F_W'(COORD_MAX))
        begin
            hit = 1'b1;
            return COORD_MAX;
        end
        if (v < F_W'(COORD_MIN))
        begin
            hit = 1'b1;
            return COORD_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    assign view_x_a   = A_W'(cfg.view_x);
    assign view_y_a   = A_W'(cfg.view_y);
    assign center_x_a = $signed({2'b00, cfg.center_x});
    assign center_y_a = $signed({2'b00, cfg.center_y});
    assign cos_k      = K_W'(cfg.rot_cos);
    assign sin_k      = K_W'(cfg.rot_sin);
    assign zoom_k     = $signed({1'b0, cfg.zoom_factor});
    assign recip_k    = $signed({1'b0, cfg.zoom_reciprocal});

    always_comb
    begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (advance)
        begin
            valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};
            op_next    = {op_reg[NUM_STAGES-3:0], in_op};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            op_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            op_reg    <= op_next;
        end
    end

    // Stage 1: remove the view position or the screen center.
    always_comb
    begin
        if (in_op == OP_W2S)
        begin
            a_next = A_W'(in_x) - view_x_a;
            b_next = A_W'(in_y) - view_y_a;
        end
        else
        begin
            a_next = A_W'(in_x) - center_x_a;
            b_next = A_W'(in_y) - center_y_a;
        end
    end

    // Stage 2: rotation products, or the reciprocal zoom on each axis.
    always_comb
    begin
        if (op_reg[0] == OP_W2S)
        begin
            m0_next = M1_W'(a_reg) * M1_W'(cos_k);
            m1_next = M1_W'(b_reg) * M1_W'(sin_k);
            m2_next = M1_W'(a_reg) * M1_W'(sin_k);
            m3_next = M1_W'(b_reg) * M1_W'(cos_k);
        end
        else
        begin
            m0_next = M1_W'(a_reg) * M1_W'(recip_k);
            m1_next = M1_W'(b_reg) * M1_W'(recip_k);
            m2_next = '0;
            m3_next = '0;
        end
    end

    // Stage 3: combine and round the first products.
    always_comb
    begin
        if (op_reg[1] == OP_W2S)
        begin
            s0 = S1_W'(m0_reg) - S1_W'(m1_reg);
            s1 = S1_W'(m2_reg) + S1_W'(m3_reg);
        end
        else
        begin
            s0 = S1_W'(m0_reg);
            s1 = S1_W'(m1_reg);
        end
        p_next = round_first(s0, op_reg[1] == OP_W2S);
        q_next = round_first(s1, op_reg[1] == OP_W2S);
    end

    // Stage 4: zoom on each axis, or the inverse rotation products.
    always_comb
    begin
        if (op_reg[2] == OP_W2S)
        begin
            n0_next = M2_W'(p_reg) * M2_W'(zoom_k);
            n1_next = '0;
            n2_next = '0;
            n3_next = M2_W'(q_reg) * M2_W'(zoom_k);
        end
        else
        begin
            n0_next = M2_W'(p_reg) * M2_W'(cos_k);
            n1_next = M2_W'(q_reg) * M2_W'(sin_k);
            n2_next = M2_W'(p_reg) * M2_W'(sin_k);
            n3_next = M2_W'(q_reg) * M2_W'(cos_k);
        end
    end

    // Stage 5: combine and round the second products.
    always_comb
    begin
        t0     = S2_W'(n0_reg) + S2_W'(n1_reg);
        t1     = S2_W'(n3_reg) - S2_W'(n2_reg);
        x_next = round_second(t0, op_reg[3] == OP_W2S);
        y_next = round_second(t1, op_reg[3] == OP_W2S);
    end

    // Stage 6: add the screen center or the view position, then saturate.
    always_comb
    begin
        if (op_reg[4] == OP_W2S)
        begin
            fx = F_W'(x_reg) + F_W'(center_x_a);
            fy = F_W'(y_reg) + F_W'(center_y_a);
        end
        else
        begin
            fx = F_W'(x_reg) + F_W'(view_x_a);
            fy = F_W'(y_reg) + F_W'(view_y_a);
        end
        ox_next  = clip(fx, sat_x);
        oy_next  = clip(fy, sat_y);
        sat_next = sat_x || sat_y;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            m3_reg  <= m3_next;
            p_reg   <= p_next;
            q_reg   <= q_next;
            n0_reg  <= n0_next;
            n1_reg  <= n1_next;
            n2_reg  <= n2_next;
            n3_reg  <= n3_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            sat_reg <= sat_next;
        end
    end

    assign stage_valid = valid_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_sat     = sat_reg;

endmodule

>>> verif/tb.sv
module tb;
    import vct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          POINTS_PER_SET = 222;
    localparam int          MAX_PRINTED    = 40;
    localparam logic [31:0] C_MAX          = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN          = 32'h8000_0000;

    typedef struct packed
    {
        logic [31:0] x;
        logic [31:0] y;
        logic        sat;
    } xform_result_t;

    typedef struct
    {
        bit            is_write;
        reg_idx_t      idx;
        logic [31:0]   wdata;
        op_t           op;
        logic [31:0]   px;
        logic [31:0]   py;
        bit            known;
        xform_result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    vct_in_if  pt_in_bus();
    vct_out_if pt_out_bus();

    view_coordinate_transform_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pt_in   (pt_in_bus),
        .pt_out  (pt_out_bus)
    );

    cfg_t          view_cfg;
    xform_result_t pending_results[$];
    stim_row_t     stim_rows[$];
    int            error_count;
    int            quiet_cycles;
    int            src_idle_pct;
    int            snk_idle_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Round half up: add half an LSB, then floor.
    function automatic longint round_shift(input longint v, input int unsigned sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [31:0] clip_coord(input longint v, output bit clipped);
        clipped = 1'b0;
        if (v > longint'($signed(C_MAX)))
        begin
            clipped = 1'b1;
            return C_MAX;
        end
        if (v < longint'($signed(C_MIN)))
        begin
            clipped = 1'b1;
            return C_MIN;
        end
        return v[31:0];
    endfunction

    function automatic xform_result_t transform_point(input op_t op, input logic [31:0] px,
                                                     input logic [31:0] py);
        longint        vx, vy, zf, zr, c, s, cx, cy, x, y;
        longint        dx, dy, tx, ty, rx, ry;
        bit            clip_x, clip_y;
        xform_result_t r;
        vx = $signed(view_cfg.view_x);
        vy = $signed(view_cfg.view_y);
        zf = view_cfg.zoom_factor;
        zr = view_cfg.zoom_reciprocal;
        c  = $signed(view_cfg.rot_cos);
        s  = $signed(view_cfg.rot_sin);
        cx = view_cfg.center_x;
        cy = view_cfg.center_y;
        x  = $signed(px);
        y  = $signed(py);
        if (op == OP_W2S)
        begin
            dx = x - vx;
            dy = y - vy;
            tx = round_shift(dx * c - dy * s, 14);
            ty = round_shift(dx * s + dy * c, 14);
            rx = cx + round_shift(tx * zf, 8);
            ry = cy + round_shift(ty * zf, 8);
        end
        else
        begin
            dx = round_shift((x - cx) * zr, 8);
            dy = round_shift((y - cy) * zr, 8);
            rx = vx + round_shift(dx * c + dy * s, 14);
            ry = vy + round_shift(dy * c - dx * s, 14);
        end
        r.x   = clip_coord(rx, clip_x);
        r.y   = clip_coord(ry, clip_y);
        r.sat = clip_x | clip_y;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        int unsigned        w;
        logic signed [31:0] v;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? C_MAX : C_MIN;
        w = $urandom_range(1, 32);
        v = $urandom;
        v = v <<< (32 - w);
        return v >>> (32 - w);
    endfunction

    function automatic stim_row_t write_row(input reg_idx_t idx, input logic [31:0] data);
        stim_row_t r;
        r          = '{idx: REG_VIEW_X, op: OP_W2S, default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.wdata    = data;
        r.op       = OP_W2S;
        return r;
    endfunction

    function automatic stim_row_t point_row(input op_t op, input logic [31:0] px,
                                           input logic [31:0] py);
        stim_row_t r;
        r     = '{idx: REG_VIEW_X, op: OP_W2S, default: '0};
        r.idx = REG_VIEW_X;
        r.op  = op;
        r.px  = px;
        r.py  = py;
        return r;
    endfunction

    function automatic stim_row_t known_row(input op_t op, input logic [31:0] px,
                                           input logic [31:0] py, input logic [31:0] rx,
                                           input logic [31:0] ry, input logic sat);
        stim_row_t r;
        r          = point_row(op, px, py);
        r.known    = 1'b1;
        r.want.x   = rx;
        r.want.y   = ry;
        r.want.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VIEW_X:     view_cfg.view_x          = data;
            REG_VIEW_Y:     view_cfg.view_y          = data;
            REG_ZOOM:       view_cfg.zoom_factor     = data[ZOOM_W-1:0];
            REG_ZOOM_RECIP: view_cfg.zoom_reciprocal = data[ZOOM_W-1:0];
            REG_ROT_COS:    view_cfg.rot_cos         = data[TRIG_W-1:0];
            REG_ROT_SIN:    view_cfg.rot_sin         = data[TRIG_W-1:0];
            REG_CENTER_X:   view_cfg.center_x        = data[CENTER_W-1:0];
            REG_CENTER_Y:   view_cfg.center_y        = data[CENTER_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // Holds the source off until every outstanding point has come back.
    task automatic drain_pipeline();
        pt_in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2)
            @(posedge clk);
    endtask

    task automatic send_point(input op_t op, input logic [31:0] px, input logic [31:0] py,
                              input bit known, input xform_result_t want);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pt_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pt_in_bus.valid     <= 1'b1;
        pt_in_bus.operation <= op;
        pt_in_bus.point_x   <= px;
        pt_in_bus.point_y   <= py;
        @(posedge clk);
        while (!pt_in_bus.ready)
            @(posedge clk);
        pending_results.push_back(known ? want : transform_point(op, px, py));
    endtask

    // Flavor 0 is a plausible camera, 1 mixes register extremes, 2 is raw noise.
    task automatic configure_random(input int flavor);
        logic [31:0] vals[8];
        int          zoom;
        drain_pipeline();
        case (flavor)
            0:
            begin
                zoom    = $urandom_range(64, 1024);
                vals[0] = rand_coord();
                vals[1] = rand_coord();
                vals[2] = zoom;
                vals[3] = 65536 / zoom;
                vals[4] = int'($urandom_range(0, 32768)) - 16384;
                vals[5] = int'($urandom_range(0, 32768)) - 16384;
                vals[6] = $urandom_range(0, 32'h0080_0000);
                vals[7] = $urandom_range(0, 32'h0080_0000);
            end
            1:
            begin
                for (int i = 0; i < 2; i++)
                    case ($urandom_range(0, 2))
                        0:       vals[i] = C_MIN;
                        1:       vals[i] = C_MAX;
                        default: vals[i] = '0;
                    endcase
                for (int i = 2; i < 4; i++)
                    case ($urandom_range(0, 2))
                        0:       vals[i] = 32'h0000_0000;
                        1:       vals[i] = 32'h0000_0001;
                        default: vals[i] = 32'h0000_ffff;
                    endcase
                for (int i = 4; i < 6; i++)
                    case ($urandom_range(0, 4))
                        0:       vals[i] = 32'hffff_c000;
                        1:       vals[i] = 32'h0000_4000;
                        2:       vals[i] = 32'h0000_0000;
                        3:       vals[i] = 32'hffff_8000;
                        default: vals[i] = 32'h0000_7fff;
                    endcase
                for (int i = 6; i < 8; i++)
                    vals[i] = $urandom_range(0, 1) ? C_MAX : 32'h0;
            end
            default:
            begin
                for (int i = 0; i < 8; i++)
                    vals[i] = $urandom;
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), vals[i]);
    endtask

    always @(posedge clk)
    begin : check_results
        xform_result_t want;
        pt_out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (pt_out_bus.valid && pt_out_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", pt_out_bus.result_x, '0);
            else
            begin
                want = pending_results.pop_front();
                if (pt_out_bus.result_x !== want.x)
                    report_mismatch("result_x", pt_out_bus.result_x, want.x);
                if (pt_out_bus.result_y !== want.y)
                    report_mismatch("result_y", pt_out_bus.result_y, want.y);
                if (pt_out_bus.saturated !== want.sat)
                    report_mismatch("saturated", 32'(pt_out_bus.saturated), 32'(want.sat));
            end
        end
        if ((pt_in_bus.valid && pt_in_bus.ready) || (pt_out_bus.valid && pt_out_bus.ready)
            || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pt_in_bus.valid     = 1'b0;
        pt_in_bus.operation = 1'b0;
        pt_in_bus.point_x   = '0;
        pt_in_bus.point_y   = '0;
        pt_out_bus.ready    = 1'b0;
        error_count         = 0;
        quiet_cycles        = 0;
        src_idle_pct        = 18;
        snk_idle_pct        = 74;

        view_cfg.view_x          = '0;
        view_cfg.view_y          = '0;
        view_cfg.zoom_factor     = ZOOM_RESET;
        view_cfg.zoom_reciprocal = ZOOM_RESET;
        view_cfg.rot_cos         = COS_RESET;
        view_cfg.rot_sin         = '0;
        view_cfg.center_x        = '0;
        view_cfg.center_y        = '0;

        // Identity view after reset: every point maps onto itself.
        stim_rows.push_back(known_row(OP_W2S, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        stim_rows.push_back(known_row(OP_W2S, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0));
        stim_rows.push_back(known_row(OP_S2W, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0));
        stim_rows.push_back(known_row(OP_S2W, 32'h0000_1000, 32'hffff_f000,
                                      32'h0000_1000, 32'hffff_f000, 1'b0));
        stim_rows.push_back(known_row(OP_W2S, 32'haaaa_aaaa, 32'h5555_5555,
                                      32'haaaa_aaaa, 32'h5555_5555, 1'b0));
        // Largest center pushes the sums past both bounds.
        stim_rows.push_back(write_row(REG_CENTER_X, C_MAX));
        stim_rows.push_back(write_row(REG_CENTER_Y, C_MAX));
        stim_rows.push_back(known_row(OP_W2S, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
        stim_rows.push_back(known_row(OP_W2S, C_MIN, C_MIN, 32'hffff_ffff, 32'hffff_ffff,
                                      1'b0));
        stim_rows.push_back(known_row(OP_S2W, C_MIN, 32'h0, C_MIN, 32'h8000_0001, 1'b1));
        stim_rows.push_back(write_row(REG_ZOOM, 32'h0000_ffff));
        stim_rows.push_back(write_row(REG_ZOOM_RECIP, 32'h0000_ffff));
        stim_rows.push_back(write_row(REG_VIEW_X, C_MIN));
        stim_rows.push_back(write_row(REG_VIEW_Y, C_MAX));
        stim_rows.push_back(point_row(OP_W2S, C_MAX, C_MIN));
        stim_rows.push_back(point_row(OP_S2W, 32'h0, 32'h0));
        // With zero zoom the scaled offset vanishes and only the offsets remain.
        stim_rows.push_back(write_row(REG_ZOOM, 32'h0));
        stim_rows.push_back(write_row(REG_ZOOM_RECIP, 32'h0));
        stim_rows.push_back(known_row(OP_W2S, 32'h1234_5678, C_MIN, C_MAX, C_MAX, 1'b0));
        stim_rows.push_back(known_row(OP_S2W, 32'h1234_5678, C_MIN, C_MIN, C_MAX, 1'b0));
        // Trig values outside the unit range are used as given.
        stim_rows.push_back(write_row(REG_ROT_COS, 32'hffff_8000));
        stim_rows.push_back(write_row(REG_ROT_SIN, 32'h0000_7fff));
        stim_rows.push_back(write_row(REG_ZOOM, 32'd256));
        stim_rows.push_back(write_row(REG_ZOOM_RECIP, 32'd256));
        stim_rows.push_back(write_row(REG_CENTER_X, 32'h0));
        stim_rows.push_back(write_row(REG_CENTER_Y, 32'h0));
        stim_rows.push_back(write_row(REG_VIEW_X, 32'h0));
        stim_rows.push_back(write_row(REG_VIEW_Y, 32'h0));
        stim_rows.push_back(point_row(OP_W2S, C_MAX, C_MIN));
        stim_rows.push_back(point_row(OP_S2W, C_MIN, C_MAX));
        stim_rows.push_back(point_row(OP_W2S, 32'h0001_2345, 32'hfffa_bcdf));
        // Quarter turn.
        stim_rows.push_back(write_row(REG_ROT_COS, 32'h0));
        stim_rows.push_back(write_row(REG_ROT_SIN, 32'hffff_c000));
        stim_rows.push_back(point_row(OP_W2S, 32'h0000_1000, 32'h0000_2000));
        stim_rows.push_back(point_row(OP_S2W, 32'h0000_1000, 32'h0000_2000));
        // Tiny factors land exactly on the half-LSB rounding points.
        stim_rows.push_back(write_row(REG_ROT_COS, 32'h1));
        stim_rows.push_back(write_row(REG_ROT_SIN, 32'h0));
        stim_rows.push_back(write_row(REG_ZOOM, 32'h1));
        stim_rows.push_back(write_row(REG_ZOOM_RECIP, 32'h1));
        stim_rows.push_back(point_row(OP_W2S, 32'h0000_2000, 32'hffff_e000));
        stim_rows.push_back(point_row(OP_S2W, 32'h0000_0080, 32'hffff_ff80));

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_write)
            begin
                drain_pipeline();
                write_reg(stim_rows[i].idx, stim_rows[i].wdata);
            end
            else
                send_point(stim_rows[i].op, stim_rows[i].px, stim_rows[i].py,
                           stim_rows[i].known, stim_rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 74 : 0;
            snk_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 18 : 0;
            for (int k = 0; k < 3; k++)
            begin
                int pause_at;
                configure_random(k);
                pause_at = $urandom_range(20, POINTS_PER_SET - 20);
                for (int n = 0; n < POINTS_PER_SET; n++)
                begin
                    if (n == pause_at)
                        drain_pipeline();
                    send_point(op_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                               1'b0, '0);
                end
            end
        end

        drain_pipeline();
        repeat (NUM_STAGES + 4)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/vct_pkg.sv
hw/rtl/vct_if.sv
hw/rtl/vct_cfg_regs.sv
hw/rtl/vct_datapath.sv
hw/rtl/view_coordinate_transform_unit.sv
verif/tb.sv
